FILE: src/graph_unavoidable_splitting_points_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers shared by the graph solver RTL.
// ----------------------------------------------------------------------------
`ifndef GRAPH_UNAVOIDABLE_SPLITTING_POINTS_MACROS_SVH
`define GRAPH_UNAVOIDABLE_SPLITTING_POINTS_MACROS_SVH

`ifndef SYNTHESIS

`define GUS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("gus assertion failed");

`define GUS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("gus assertion failed");

`else

`define GUS_ASSERT_IMPL(label, clk, rst_n, ante, cons)

`define GUS_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: src/gus_pkg.sv
// ----------------------------------------------------------------------------
// gus_pkg
// Types and constants of the unavoidable and splitting point solver.
// ----------------------------------------------------------------------------
`default_nettype none

package gus_pkg;

	localparam int CMD_W  = 2;
	localparam int NODE_W = 6;
	localparam int CNT_W  = 7;

	localparam logic [CMD_W-1:0] CMD_ADD   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_SOLVE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

	localparam logic [CNT_W-1:0] NODE_COUNT_RST = 7'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ARC_WR,
		ST_WALK_INIT,
		ST_WALK,
		ST_SPLIT,
		ST_SPLIT_DRAIN,
		ST_REPORT,
		ST_NEXT,
		ST_FINISH
	} gus_state_t;

endpackage

`default_nettype wire

FILE: src/gus_ram.sv
// ----------------------------------------------------------------------------
// gus_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module gus_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

FILE: src/graph_unavoidable_splitting_points.sv
// ----------------------------------------------------------------------------
// graph_unavoidable_splitting_points
// Finds the unavoidable and splitting nodes of a stored directed graph.
// ----------------------------------------------------------------------------
// Input words carry a command in s_tuser and two node numbers in s_tdata.
// An add-arc word sets one bit of the adjacency RAM, a clear word empties the
// graph, and cfg_we/cfg_wdata set node_count.
// A solve word takes each candidate node 1 .. n-2 in turn. For each one the
// sequencer walks the graph from node 0 by reading one adjacency row per cycle
// and repeating its scan until no pending node is left, then, if the finish
// is cut off, scans all n rows once more for the splitting test. One row read
// per cycle on the single RAM read port sets the pace. s_tready stays low
// until the solve has handed its final word to the output register.
// Results leave through a one-word output register; a stalled receiver holds
// that word and, once the next result is ready, the sequencer waits with it.
// The last word of a solve carries m_tlast; an empty solve yields one word
// with m_tuser low. Reset empties the graph at once through per-row valid
// bits, sets node_count to 2 and drops any pending output.
// ----------------------------------------------------------------------------
`default_nettype none

`include "graph_unavoidable_splitting_points_macros.svh"

module graph_unavoidable_splitting_points #(
	parameter int MAX_NODES = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [6:0]  cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // from_node[5:0], to_node[11:6], zero pad
	input  logic [1:0]  s_tuser,   // cmd[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // node[5:0], is_splitting[6], zero pad
	output logic        m_tuser,   // entry_valid
	output logic        m_tlast    // last
);

	localparam int IW = $clog2(MAX_NODES);
	localparam int CW = IW + 8;
	localparam int EW = IW + 6;

	gus_pkg::gus_state_t state_q, state_d;

	logic [gus_pkg::CNT_W-1:0] node_count_q;
	logic [MAX_NODES-1:0]      row_valid_q;
	logic [MAX_NODES-1:0]      reach_q;
	logic [MAX_NODES-1:0]      pend_q;
	logic [MAX_NODES-1:0]      mask_q;
	logic [IW-1:0]             k_q;
	logic [IW-1:0]             x_q;
	logic [IW-1:0]             nlast_q;
	logic [IW-1:0]             arc_row_q;
	logic [IW-1:0]             arc_to_q;
	logic                      v_s1;
	logic                      cond_s1;
	logic                      rv_s1;
	logic                      split_ok_q;
	logic                      hold_v_q;
	logic [gus_pkg::NODE_W-1:0] hold_node_q;
	logic                      hold_split_q;
	logic                      m_tvalid_q;
	logic [7:0]                m_tdata_q;
	logic                      m_tuser_q;
	logic                      m_tlast_q;

	logic [gus_pkg::CMD_W-1:0]  in_cmd;
	logic [gus_pkg::NODE_W-1:0] in_from;
	logic [gus_pkg::NODE_W-1:0] in_to;
	logic [EW-1:0]              from_ext;
	logic [EW-1:0]              to_ext;
	logic [EW-1:0]              k_ext;
	logic                       arc_ok;
	logic [CW-1:0]              ncx;
	logic [CW-1:0]              nlast_w;
	logic [IW-1:0]              nlast_in;
	logic [MAX_NODES-1:0]       kbit;
	logic [MAX_NODES-1:0]       xbit;
	logic [MAX_NODES-1:0]       tobit;
	logic [MAX_NODES-1:0]       ram_rdata;
	logic [MAX_NODES-1:0]       rowdata;
	logic [MAX_NODES-1:0]       newb;
	logic                       bad;
	logic                       in_acc;
	logic                       out_free;
	logic                       k_end;
	logic                       walk_done;

	logic                       issue;
	logic                       ram_we;
	logic [IW-1:0]              ram_raddr;
	logic                       out_load;
	logic [gus_pkg::NODE_W-1:0] out_node;
	logic                       out_split;
	logic                       out_ev;
	logic                       out_last;

	assign in_cmd   = s_tuser;
	assign in_from  = s_tdata[5:0];
	assign in_to    = s_tdata[11:6];
	assign from_ext = EW'(in_from);
	assign to_ext   = EW'(in_to);
	assign arc_ok   = (from_ext < EW'(MAX_NODES)) && (to_ext < EW'(MAX_NODES));
	assign k_ext    = EW'(k_q);

	assign ncx = CW'(node_count_q);

	always_comb begin
		priority if (ncx < CW'(2)) begin
			nlast_w = CW'(1);
		end else if (ncx > CW'(MAX_NODES)) begin
			nlast_w = CW'(MAX_NODES - 1);
		end else begin
			nlast_w = ncx - CW'(1);
		end
	end

	assign nlast_in = nlast_w[IW-1:0];

	assign kbit  = {{(MAX_NODES-1){1'b0}}, 1'b1} << k_q;
	assign xbit  = {{(MAX_NODES-1){1'b0}}, 1'b1} << x_q;
	assign tobit = {{(MAX_NODES-1){1'b0}}, 1'b1} << arc_to_q;

	assign rowdata   = rv_s1 ? ram_rdata : '0;
	assign newb      = rowdata & ~reach_q & mask_q;
	assign bad       = |(rowdata & reach_q & ~kbit);
	assign in_acc    = s_tvalid && s_tready;
	assign out_free  = !m_tvalid_q || m_tready;
	assign k_end     = (k_q == (nlast_q - IW'(1)));
	assign walk_done = (pend_q == '0) && !v_s1;

	gus_ram #(
		.WIDTH(MAX_NODES),
		.DEPTH(MAX_NODES)
	) u_adj_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(arc_row_q),
		.wdata(rowdata | tobit),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			gus_pkg::ST_IDLE: begin
				if (in_acc) begin
					priority if (in_cmd == gus_pkg::CMD_ADD && arc_ok) begin
						state_d = gus_pkg::ST_ARC_WR;
					end else if (in_cmd == gus_pkg::CMD_SOLVE) begin
						state_d = (nlast_in == IW'(1)) ? gus_pkg::ST_FINISH
						                               : gus_pkg::ST_WALK_INIT;
					end else begin
						state_d = gus_pkg::ST_IDLE;
					end
				end
			end
			gus_pkg::ST_ARC_WR: begin
				state_d = gus_pkg::ST_IDLE;
			end
			gus_pkg::ST_WALK_INIT: begin
				state_d = gus_pkg::ST_WALK;
			end
			gus_pkg::ST_WALK: begin
				if (walk_done) begin
					state_d = reach_q[nlast_q] ? gus_pkg::ST_NEXT : gus_pkg::ST_SPLIT;
				end
			end
			gus_pkg::ST_SPLIT: begin
				if (x_q == nlast_q) begin
					state_d = gus_pkg::ST_SPLIT_DRAIN;
				end
			end
			gus_pkg::ST_SPLIT_DRAIN: begin
				state_d = gus_pkg::ST_REPORT;
			end
			gus_pkg::ST_REPORT: begin
				if (!hold_v_q || out_free) begin
					state_d = gus_pkg::ST_NEXT;
				end
			end
			gus_pkg::ST_NEXT: begin
				state_d = k_end ? gus_pkg::ST_FINISH : gus_pkg::ST_WALK_INIT;
			end
			gus_pkg::ST_FINISH: begin
				if (out_free) begin
					state_d = gus_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = gus_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		s_tready  = 1'b0;
		issue     = 1'b0;
		ram_we    = 1'b0;
		ram_raddr = x_q;
		out_load  = 1'b0;
		out_node  = hold_node_q;
		out_split = hold_split_q;
		out_ev    = 1'b1;
		out_last  = 1'b0;
		unique case (state_q)
			gus_pkg::ST_IDLE: begin
				s_tready  = 1'b1;
				ram_raddr = from_ext[IW-1:0];
			end
			gus_pkg::ST_ARC_WR: begin
				ram_we = 1'b1;
			end
			gus_pkg::ST_WALK: begin
				issue = pend_q[x_q];
			end
			gus_pkg::ST_SPLIT: begin
				issue = 1'b1;
			end
			gus_pkg::ST_REPORT: begin
				out_load = hold_v_q && out_free;
			end
			gus_pkg::ST_FINISH: begin
				out_load = out_free;
				out_last = 1'b1;
				if (!hold_v_q) begin
					out_node  = '0;
					out_split = 1'b0;
					out_ev    = 1'b0;
				end
			end
			default: begin
				issue = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= gus_pkg::ST_IDLE;
			node_count_q <= gus_pkg::NODE_COUNT_RST;
			row_valid_q  <= '0;
			v_s1         <= 1'b0;
			hold_v_q     <= 1'b0;
			m_tvalid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			v_s1    <= issue;
			if (cfg_we) begin
				node_count_q <= cfg_wdata;
			end
			if (in_acc && in_cmd == gus_pkg::CMD_CLEAR) begin
				row_valid_q <= '0;
			end else if (ram_we) begin
				row_valid_q[arc_row_q] <= 1'b1;
			end
			if (in_acc && in_cmd == gus_pkg::CMD_SOLVE) begin
				hold_v_q <= 1'b0;
			end else if (state_q == gus_pkg::ST_REPORT && state_d == gus_pkg::ST_NEXT) begin
				hold_v_q <= 1'b1;
			end else if (state_q == gus_pkg::ST_FINISH && out_free) begin
				hold_v_q <= 1'b0;
			end
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		rv_s1   <= row_valid_q[ram_raddr];
		cond_s1 <= !reach_q[x_q] || (x_q == k_q);
		unique case (state_q)
			gus_pkg::ST_IDLE: begin
				if (in_acc) begin
					arc_row_q <= from_ext[IW-1:0];
					arc_to_q  <= to_ext[IW-1:0];
					nlast_q   <= nlast_in;
					k_q       <= IW'(1);
					for (int i = 0; i < MAX_NODES; i++) begin
						mask_q[i] <= (CW'(i) <= CW'(nlast_in));
					end
				end
			end
			gus_pkg::ST_WALK_INIT: begin
				reach_q    <= {{(MAX_NODES-1){1'b0}}, 1'b1} | kbit;
				pend_q     <= {{(MAX_NODES-1){1'b0}}, 1'b1};
				x_q        <= '0;
				split_ok_q <= 1'b1;
			end
			gus_pkg::ST_WALK: begin
				pend_q  <= (pend_q & ~(issue ? xbit : '0)) | (v_s1 ? newb : '0);
				reach_q <= reach_q | (v_s1 ? newb : '0);
				if (walk_done || x_q == nlast_q) begin
					x_q <= '0;
				end else begin
					x_q <= x_q + IW'(1);
				end
			end
			gus_pkg::ST_SPLIT: begin
				x_q <= x_q + IW'(1);
				if (v_s1 && cond_s1 && bad) begin
					split_ok_q <= 1'b0;
				end
			end
			gus_pkg::ST_SPLIT_DRAIN: begin
				if (v_s1 && cond_s1 && bad) begin
					split_ok_q <= 1'b0;
				end
			end
			gus_pkg::ST_REPORT: begin
				if (state_d == gus_pkg::ST_NEXT) begin
					hold_node_q  <= k_ext[gus_pkg::NODE_W-1:0];
					hold_split_q <= split_ok_q;
				end
			end
			gus_pkg::ST_NEXT: begin
				if (!k_end) begin
					k_q <= k_q + IW'(1);
				end
			end
			default: begin
				x_q <= x_q;
			end
		endcase
		if (out_load) begin
			m_tdata_q <= {1'b0, out_split, out_node};
			m_tuser_q <= out_ev;
			m_tlast_q <= out_last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;

	`GUS_ASSERT_IMPL(a_empty_is_last, clk, arst_n, m_tvalid_q && !m_tuser_q, m_tlast_q)
	`GUS_ASSERT_IMPL(a_pend_in_reach, clk, arst_n, state_q == gus_pkg::ST_WALK,
		(pend_q & ~reach_q) == '0)
	`GUS_ASSERT_IMPL(a_cand_range, clk, arst_n, state_q == gus_pkg::ST_WALK,
		k_q != '0 && k_q < nlast_q)
	`GUS_ASSERT_NEXT(a_busy_after_solve, clk, arst_n,
		in_acc && in_cmd == gus_pkg::CMD_SOLVE, !s_tready)

endmodule

`default_nettype wire

FILE: tb/sv/tb_graph_unavoidable_splitting_points.sv
// ----------------------------------------------------------------------------
// tb_graph_unavoidable_splitting_points
// Self-checking bench for the unavoidable and splitting point solver.
// ----------------------------------------------------------------------------
// A short table of directed words covers reset values, clamped node counts,
// arcs outside the live range, duplicate arcs, the unused command, the empty
// report and a full-size report. Random phases then pick a node count, load
// mostly path-shaped graphs with noise between the arcs, and solve them. An
// internal graph model predicts every report word, and each word that leaves
// the block is compared with the oldest prediction. Both stream sides idle
// at random between words.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_graph_unavoidable_splitting_points;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [gus_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam int unsigned RANDOM_WORDS = 300;
	localparam int unsigned SETTLE_CYCLES = 8;
	localparam int unsigned TAIL_CYCLES = 50;
	localparam int unsigned CYCLE_LIMIT = 3000000;
	localparam int unsigned SCRIPT_ROWS = 24;

	typedef struct packed {
		logic [5:0] node;
		logic       splitting;
		logic       entry_valid;
		logic       last;
	} split_report_t;

	localparam split_report_t NO_NODE = '{node: 6'd0, splitting: 1'b0,
		entry_valid: 1'b0, last: 1'b1};

	typedef enum logic {ROW_WORD, ROW_CFG} row_kind_t;

	typedef struct packed {
		row_kind_t                 kind;
		logic [gus_pkg::CMD_W-1:0] cmd;
		logic [5:0]                src;
		logic [5:0]                dst;
		logic [6:0]                count;
		logic                      typed_empty;
	} stim_row_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_we = 1'b0;
	logic [6:0]        cfg_wdata = '0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [15:0]       s_tdata = '0;
	logic [1:0]        s_tuser = '0;
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [7:0]        m_tdata;
	logic              m_tuser;
	logic              m_tlast;

	logic [63:0]       graph_adj [64];
	int unsigned       live_count = 2;
	split_report_t     pending_reports [$];
	split_report_t     want_report;
	split_report_t     got_report;
	stim_row_t         script [SCRIPT_ROWS];

	bit                sender_burst = 1'b0;
	bit                receiver_burst = 1'b0;
	int unsigned       errors = 0;
	int unsigned       words_counted = 0;
	int unsigned       solves_sent = 0;
	int unsigned       reports_seen = 0;
	int unsigned       settings_written = 0;
	int unsigned       cycle_count = 0;

	graph_unavoidable_splitting_points dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: run did not complete within %0d cycles", $time, CYCLE_LIMIT);
			$display("TEST FAILED");
			$finish;
		end
	end

	function automatic void add_expected(input split_report_t rep);
		pending_reports = {pending_reports, rep};
	endfunction

	function automatic void solve_graph();
		logic [63:0]   live_mask;
		logic [63:0]   seen;
		logic [63:0]   wave;
		logic [63:0]   grow;
		logic [63:0]   cut;
		bit            splits;
		bit            holding;
		split_report_t held;
		holding = 1'b0;
		held = NO_NODE;
		live_mask = (live_count >= 64) ? '1 : ((64'd1 << live_count) - 64'd1);
		for (int k = 1; k < live_count; k++) begin
			seen = 64'd1 | (64'd1 << k);
			wave = 64'd1;
			while (wave != '0) begin
				grow = '0;
				for (int x = 0; x < live_count; x++)
					if (wave[x])
						grow |= graph_adj[x] & live_mask & ~seen;
				seen |= grow;
				wave = grow;
			end
			if (!seen[live_count-1]) begin
				cut = seen & ~(64'd1 << k);
				splits = 1'b1;
				for (int x = 0; x < live_count; x++)
					if ((!seen[x] || x == k) && (graph_adj[x] & live_mask & cut) != '0)
						splits = 1'b0;
				if (holding)
					add_expected(held);
				held = '{node: k[5:0], splitting: splits, entry_valid: 1'b1, last: 1'b0};
				holding = 1'b1;
			end
		end
		if (holding)
			held.last = 1'b1;
		add_expected(held);
	endfunction

	task automatic hold_until_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_reports.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_node_count(input logic [6:0] value);
		hold_until_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		live_count = (value < 7'd2) ? 2 : ((value > 7'd64) ? 64 : int'(value));
		settings_written++;
	endtask

	task automatic send_word(input logic [gus_pkg::CMD_W-1:0] cmd, input logic [5:0] src,
			input logic [5:0] dst, input bit typed_empty);
		int unsigned gap;
		gap = sender_burst ? 0 : $urandom_range(0, 14);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= {4'b0, dst, src};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		if (cmd != CMD_UNUSED)
			words_counted++;
		unique case (cmd)
			gus_pkg::CMD_ADD: graph_adj[src][dst] = 1'b1;
			gus_pkg::CMD_CLEAR: begin
				for (int i = 0; i < 64; i++)
					graph_adj[i] = '0;
			end
			gus_pkg::CMD_SOLVE: begin
				solves_sent++;
				if (typed_empty)
					add_expected(NO_NODE);
				else
					solve_graph();
			end
			default: ;
		endcase
	endtask

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			reports_seen++;
			got_report = {m_tdata[5:0], m_tdata[6], m_tuser, m_tlast};
			if (pending_reports.size() == 0) begin
				$display("%0t: unexpected word, expected none, ", $time,
					"got node %0d split %0b valid %0b last %0b",
					got_report.node, got_report.splitting,
					got_report.entry_valid, got_report.last);
				errors++;
			end else begin
				want_report = pending_reports.pop_front();
				if (got_report != want_report) begin
					$display("%0t: mismatch, expected node %0d split %0b valid %0b last %0b",
						$time, want_report.node, want_report.splitting,
						want_report.entry_valid, want_report.last,
						", got node %0d split %0b valid %0b last %0b",
						got_report.node, got_report.splitting,
						got_report.entry_valid, got_report.last);
					errors++;
				end
			end
		end
	end

	initial begin : drain_side
		int unsigned stall;
		@(posedge arst_n);
		forever begin
			stall = receiver_burst ? 0 : $urandom_range(0, 14);
			if (stall != 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid)
				@(posedge clk);
		end
	end

	initial begin : source_side
		int unsigned random_target;
		int unsigned phase;
		int unsigned pick;
		int unsigned span;
		int unsigned extra;
		int unsigned hop;
		logic [6:0]  raw_count;

		for (int i = 0; i < 64; i++)
			graph_adj[i] = '0;

		script = '{
			'{ROW_WORD, gus_pkg::CMD_SOLVE, 6'd0,  6'd0,  7'd0,   1'b1},
			'{ROW_WORD, gus_pkg::CMD_ADD,   6'd0,  6'd1,  7'd0,   1'b0},
			'{ROW_WORD, gus_pkg::CMD_SOLVE, 6'd0,  6'd0,  7'd0,   1'b1},
			'{ROW_CFG,  gus_pkg::CMD_ADD,   6'd0,  6'd0,  7'd4,   1'b0},
			'{ROW_WORD, gus_pkg::CMD_ADD,   6'd1,  6'd2,  7'd0,   1'b0},
			'{ROW_WORD, gus_pkg::CMD_ADD,   6'd2,  6'd3,  7'd0,   1'b0},
			'{ROW_WORD, gus_pkg::CMD_ADD,   6'd2,  6'd3,  7'd0,   1'b0},
			'{ROW_WORD, gus_pkg::CMD_ADD,   6'd3,  6'd63, 7'd0,   1'b0},
			'{ROW_WORD, gus_pkg::CMD_ADD,   6'd63, 6'd63, 7'd0,   1'b0},
			'{ROW_WORD, gus_pkg::CMD_ADD,   6'd5,  6'd0,  7'd0,   1'b0},
			'{ROW_WORD, CMD_UNUSED,         6'd63, 6'd63, 7'd0,   1'b0},
			'{ROW_WORD, gus_pkg::CMD_SOLVE, 6'd63, 6'd63, 7'd0,   1'b0},
			'{ROW_WORD, gus_pkg::CMD_ADD,   6'd0,  6'd2,  7'd0,   1'b0},
			'{ROW_WORD, gus_pkg::CMD_SOLVE, 6'd0,  6'd0,  7'd0,   1'b0},
			'{ROW_WORD, gus_pkg::CMD_CLEAR, 6'd0,  6'd0,  7'd0,   1'b0},
			'{ROW_WORD, gus_pkg::CMD_SOLVE, 6'd0,  6'd0,  7'd0,   1'b0},
			'{ROW_CFG,  gus_pkg::CMD_ADD,   6'd0,  6'd0,  7'd0,   1'b0},
			'{ROW_WORD, gus_pkg::CMD_SOLVE, 6'd0,  6'd0,  7'd0,   1'b1},
			'{ROW_CFG,  gus_pkg::CMD_ADD,   6'd0,  6'd0,  7'd127, 1'b0},
			'{ROW_WORD, gus_pkg::CMD_ADD,   6'd0,  6'd63, 7'd0,   1'b0},
			'{ROW_WORD, gus_pkg::CMD_SOLVE, 6'd0,  6'd0,  7'd0,   1'b1},
			'{ROW_CFG,  gus_pkg::CMD_ADD,   6'd0,  6'd0,  7'd64,  1'b0},
			'{ROW_WORD, gus_pkg::CMD_CLEAR, 6'd0,  6'd0,  7'd0,   1'b0},
			'{ROW_WORD, gus_pkg::CMD_SOLVE, 6'd0,  6'd0,  7'd0,   1'b0}
		};

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < SCRIPT_ROWS; r++) begin
			if (script[r].kind == ROW_CFG)
				write_node_count(script[r].count);
			else
				send_word(script[r].cmd, script[r].src, script[r].dst, script[r].typed_empty);
		end

		random_target = words_counted + RANDOM_WORDS;
		phase = 0;
		while (words_counted < random_target) begin
			phase++;
			sender_burst = ($urandom_range(0, 3) == 0);
			receiver_burst = ($urandom_range(0, 3) == 0);
			pick = $urandom_range(0, 19);
			if (phase == 6)
				raw_count = 7'd64;
			else if (pick == 0)
				raw_count = $urandom_range(0, 1) ? 7'($urandom_range(0, 1))
					: 7'($urandom_range(65, 127));
			else if (pick < 5)
				raw_count = 7'($urandom_range(13, 24));
			else
				raw_count = 7'($urandom_range(2, 12));
			write_node_count(raw_count);
			span = (live_count > 24 && phase != 6) ? 8 : live_count;

			if ($urandom_range(0, 3) != 0)
				send_word(gus_pkg::CMD_CLEAR, 6'($urandom_range(0, 63)),
					6'($urandom_range(0, 63)), 1'b0);

			if ($urandom_range(0, 3) != 0) begin
				for (int i = 0; i + 1 < span; i++) begin
					if ($urandom_range(0, 7) != 0)
						send_word(gus_pkg::CMD_ADD, i[5:0], 6'(i + 1), 1'b0);
					hop = $urandom_range(2, 4);
					if ($urandom_range(0, 3) == 0 && i + hop < span)
						send_word(gus_pkg::CMD_ADD, i[5:0], 6'(i + hop), 1'b0);
					if ($urandom_range(0, 9) == 0)
						send_word($urandom_range(0, 1) ? CMD_UNUSED : gus_pkg::CMD_ADD,
							6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)), 1'b0);
				end
				extra = $urandom_range(0, span / 2);
			end else begin
				extra = $urandom_range(1, span + 2);
			end
			for (int i = 0; i < extra; i++)
				send_word(gus_pkg::CMD_ADD, 6'($urandom_range(0, span - 1)),
					6'($urandom_range(0, span - 1)), 1'b0);

			send_word(gus_pkg::CMD_SOLVE, 6'($urandom_range(0, 63)),
				6'($urandom_range(0, 63)), 1'b0);

			if (phase == 1 || $urandom_range(0, 3) == 0)
				hold_until_drained();

			if ($urandom_range(0, 1) == 0) begin
				extra = $urandom_range(1, 3);
				for (int i = 0; i < extra; i++)
					send_word(gus_pkg::CMD_ADD, 6'($urandom_range(0, span - 1)),
						6'($urandom_range(0, span - 1)), 1'b0);
				send_word(gus_pkg::CMD_SOLVE, 6'($urandom_range(0, 63)),
					6'($urandom_range(0, 63)), 1'b0);
			end
		end

		hold_until_drained();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Summary: %0d words in %0d solves, %0d reports checked, %0d node counts",
			words_counted, solves_sent, reports_seen, settings_written);
		$display("Node counts ranged from clamped low values up to 64 with random idling.");
		if (errors == 0 && pending_reports.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("%0d mismatches, %0d reports still pending", errors,
				pending_reports.size());
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

`default_nettype wire
